// ----- sv/piecewise_accel_profile_eval_unit_assert.svh -----
// Assertion macros shared by the motion profile evaluation unit.
`ifndef PIECEWISE_ACCEL_PROFILE_EVAL_UNIT_ASSERT_SVH
`define PIECEWISE_ACCEL_PROFILE_EVAL_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PAPE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PAPE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/pape_pkg.sv -----
// Types and constants of the motion profile evaluation unit.
package pape_pkg;

  localparam int MAX_KNOTS_DEFAULT = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam int TIME_W = 32;
  localparam int VEL_W = 32;
  localparam int POS_W = 48;

  // Multiplier: 48-bit magnitude times 32-bit time, 16 bits per step.
  localparam int MUL_X_W = 48;
  localparam int MUL_CHUNK = 16;
  localparam int MUL_STEPS = MUL_X_W / MUL_CHUNK;
  localparam int MUL_ACC_W = MUL_X_W + TIME_W;
  localparam int MUL_MAG_W = 63;

  // Divider: (|dv| << 16) has 49 bits.
  localparam int DIV_BITS = 49;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FEW   = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_ORDER = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_BEFORE = 2'd0,
    REG_MID    = 2'd1,
    REG_AFTER  = 2'd2
  } region_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_SRCH_ADDR,
    ST_SRCH_CMP,
    ST_FETCH,
    ST_LOAD,
    ST_MUL_A,
    ST_MUL_V,
    ST_MUL_AA,
    ST_FINISH,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [TIME_W-1:0]  time_req;
    logic [VEL_W-1:0]   velocity;
  } item_t;

  typedef struct packed {
    logic               start;
    logic               x_neg;
    logic [MUL_X_W-1:0] x_mag;
    logic [TIME_W-1:0]  y;
  } mul_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic                 neg;
    logic [MUL_MAG_W-1:0] mag;
  } mul_rsp_t;

endpackage

// ----- sv/pape_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pape_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/pape_mul.sv -----
// Sequential sign-magnitude Q16 multiplier, one 16-bit partial product per cycle.
module pape_mul (
  input  logic               clk,
  input  logic               rst,
  input  pape_pkg::mul_req_t req,
  output pape_pkg::mul_rsp_t rsp
);

  localparam int SW = $clog2(pape_pkg::MUL_STEPS + 1);
  localparam logic [63:0] MAG_LIMIT = 64'h4000_0000_0000_0000;

  logic                              busy;
  logic                              done;
  logic [SW-1:0]                     step;
  logic                              neg;
  logic [pape_pkg::MUL_X_W-1:0]      x_mag;
  logic [pape_pkg::TIME_W-1:0]       y;
  logic [pape_pkg::MUL_ACC_W-1:0]    acc;
  logic [pape_pkg::MUL_CHUNK-1:0]    chunk;
  logic [pape_pkg::MUL_CHUNK+pape_pkg::TIME_W-1:0] pp;
  logic [pape_pkg::MUL_ACC_W-1:0]    pp_shifted;
  logic [63:0]                       quot;

  always_comb begin
    chunk = x_mag[step * pape_pkg::MUL_CHUNK +: pape_pkg::MUL_CHUNK];
    pp = chunk * y;
    pp_shifted = pape_pkg::MUL_ACC_W'(pp) << (step * pape_pkg::MUL_CHUNK);
    quot = acc[pape_pkg::MUL_ACC_W-1:pape_pkg::MUL_CHUNK];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == SW'(pape_pkg::MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg   <= req.x_neg;
      x_mag <= req.x_mag;
      y     <= req.y;
      acc   <= '0;
    end else if (busy) begin
      acc <= acc + pp_shifted;
    end
  end

  always_comb begin
    rsp.busy = busy;
    rsp.done = done;
    rsp.neg  = neg;
    rsp.mag  = (quot > MAG_LIMIT) ? MAG_LIMIT[pape_pkg::MUL_MAG_W-1:0]
                                  : quot[pape_pkg::MUL_MAG_W-1:0];
  end

endmodule

// ----- sv/pape_front.sv -----
// Front end: accepts requests, decodes the mode and queues them for the back end.
module pape_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [1:0]          mode,
  input  logic [31:0]         time_req,
  input  logic signed [31:0]  velocity,
  output logic                q_valid,
  output pape_pkg::item_t     q_item,
  input  logic                q_pop
);

  localparam int PW = $clog2(pape_pkg::QUEUE_DEPTH);
  localparam int FW = $clog2(pape_pkg::QUEUE_DEPTH + 1);

  pape_pkg::item_t q_mem [pape_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [FW-1:0]   fill;
  logic            push;
  pape_pkg::item_t item_in;

  always_comb begin
    item_in.time_req = time_req;
    item_in.velocity = velocity;
    case (mode)
      pape_pkg::MODE_APPEND: item_in.op = pape_pkg::OP_APPEND;
      pape_pkg::MODE_QUERY:  item_in.op = pape_pkg::OP_QUERY;
      pape_pkg::MODE_CLEAR:  item_in.op = pape_pkg::OP_CLEAR;
      default:               item_in.op = pape_pkg::OP_NONE;
    endcase
  end

  assign req_stall = (fill == FW'(pape_pkg::QUEUE_DEPTH));
  assign push      = req_valid && !req_stall;
  assign q_valid   = (fill != '0);
  assign q_item    = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= item_in;
    end
  end

endmodule

// ----- sv/pape_back.sv -----
// Back end: knot table, upper-bound search, divider and segment evaluation.
module pape_back #(
  parameter int MAX_KNOTS = pape_pkg::MAX_KNOTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  pape_pkg::item_t     q_item,
  output logic                q_pop,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [47:0]         start_position,
  output pape_pkg::mul_req_t  mul_req,
  input  pape_pkg::mul_rsp_t  mul_rsp,
  output logic                res_valid,
  input  logic                res_stall,
  output logic [47:0]         position,
  output logic [31:0]         speed,
  output logic [31:0]         accel,
  output logic [1:0]          status
);

  `include "piecewise_accel_profile_eval_unit_assert.svh"

  localparam int AW = $clog2(MAX_KNOTS);
  localparam int CW = $clog2(MAX_KNOTS + 1);
  localparam int DCW = $clog2(pape_pkg::DIV_BITS);
  localparam logic signed [63:0] POS_MAX = 64'sd140737488355327;
  localparam logic signed [63:0] POS_MIN = -64'sd140737488355328;

  function automatic logic [47:0] clamp48(input logic signed [63:0] x);
    logic [47:0] r;
    if (x > POS_MAX) begin
      r = POS_MAX[47:0];
    end else if (x < POS_MIN) begin
      r = POS_MIN[47:0];
    end else begin
      r = x[47:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  pape_pkg::state_t  state, state_next;
  pape_pkg::op_t     cur_op;
  pape_pkg::region_t region;
  pape_pkg::status_t stat_stage;

  logic [47:0]        start_pos;
  logic [CW-1:0]      count;
  logic [31:0]        last_time;
  logic [31:0]        last_speed;
  logic [47:0]        last_pos;
  logic [31:0]        t_reg;
  logic [31:0]        vel_reg;
  logic [CW-1:0]      lo;
  logic [CW-1:0]      hi;
  logic [31:0]        ks;
  logic [31:0]        a_reg;
  logic [31:0]        dt_reg;
  logic               m1_neg;
  logic [47:0]        m1_mag;
  logic signed [63:0] pos_acc;
  logic [31:0]        spd_res;
  logic [31:0]        acc_res;
  logic [47:0]        pos_stage;
  logic [31:0]        spd_stage;
  logic [31:0]        acc_stage;
  logic [31:0]        div_rem;
  logic [pape_pkg::DIV_BITS-1:0] div_q;
  logic [DCW-1:0]     div_cnt;
  logic               div_neg;
  logic               mul_issued;

  logic [CW:0]        mid_sum;
  logic [CW-1:0]      mid;
  logic [CW-1:0]      count_m1;
  logic [CW-1:0]      lo_m1;
  logic [AW-1:0]      raddr;
  logic               wr_knot;
  logic               wr_accel;
  logic [47:0]        pos_final;
  logic [31:0]        rd_time;
  logic [31:0]        rd_speed;
  logic [47:0]        rd_pos;
  logic [31:0]        rd_accel;
  logic [32:0]        div_trial;
  logic               div_ge;
  logic [pape_pkg::DIV_BITS-1:0] div_q_step;
  logic [31:0]        div_a;
  logic signed [32:0] dv;
  logic [32:0]        dv_mag;
  logic signed [63:0] mul_s;
  logic signed [63:0] mul_half;
  logic signed [49:0] m1_s;
  logic signed [49:0] spd_sum;
  logic [31:0]        spd_sat;
  logic               mul_state;
  logic               out_free;

  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid       = mid_sum[CW:1];
  assign count_m1  = count - 1'b1;
  assign lo_m1     = lo - 1'b1;
  assign pos_final = clamp48(pos_acc);
  assign cfg_ready = 1'b1;
  assign out_free  = !res_valid || !res_stall;

  // Divider step, final saturation of the acceleration and the velocity difference.
  always_comb begin
    div_trial  = {div_rem, div_q[pape_pkg::DIV_BITS-1]};
    div_ge     = (div_trial >= {1'b0, dt_reg});
    div_q_step = {div_q[pape_pkg::DIV_BITS-2:0], div_ge};
    if (div_neg) begin
      div_a = (div_q_step > pape_pkg::DIV_BITS'(33'h0_8000_0000)) ? 32'h8000_0000
                                                                : (~div_q_step[31:0] + 32'd1);
    end else begin
      div_a = (div_q_step > pape_pkg::DIV_BITS'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                                : div_q_step[31:0];
    end
    dv     = $signed({q_item.velocity[31], q_item.velocity})
           - $signed({last_speed[31], last_speed});
    dv_mag = dv[32] ? (~dv + 33'd1) : dv;
  end

  // Signed views of the multiplier result and the saturated speed sum.
  always_comb begin
    mul_s    = mul_rsp.neg ? -$signed({1'b0, mul_rsp.mag}) : $signed({1'b0, mul_rsp.mag});
    mul_half = mul_rsp.neg ? -$signed({2'b0, mul_rsp.mag[62:1]})
                           : $signed({2'b0, mul_rsp.mag[62:1]});
    m1_s     = mul_rsp.neg ? -$signed({2'b0, mul_rsp.mag[47:0]})
                           : $signed({2'b0, mul_rsp.mag[47:0]});
    spd_sum  = $signed({{18{ks[31]}}, ks}) + m1_s;
    if (spd_sum > 50'sd2147483647) begin
      spd_sat = 32'h7FFF_FFFF;
    end else if (spd_sum < -50'sd2147483648) begin
      spd_sat = 32'h8000_0000;
    end else begin
      spd_sat = spd_sum[31:0];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      pape_pkg::ST_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            pape_pkg::OP_APPEND: begin
              if (count == CW'(MAX_KNOTS)) begin
                state_next = pape_pkg::ST_DONE;
              end else if (count != '0 && q_item.time_req <= last_time) begin
                state_next = pape_pkg::ST_DONE;
              end else if (count == '0) begin
                state_next = pape_pkg::ST_FINISH;
              end else begin
                state_next = pape_pkg::ST_DIV;
              end
            end
            pape_pkg::OP_QUERY: begin
              state_next = (count < CW'(2)) ? pape_pkg::ST_DONE : pape_pkg::ST_SRCH_ADDR;
            end
            default: state_next = pape_pkg::ST_DONE;
          endcase
        end
      end
      pape_pkg::ST_DIV:       if (div_cnt == '0) state_next = pape_pkg::ST_MUL_A;
      pape_pkg::ST_SRCH_ADDR: begin
        state_next = (lo < hi) ? pape_pkg::ST_SRCH_CMP : pape_pkg::ST_FETCH;
      end
      pape_pkg::ST_SRCH_CMP:  state_next = pape_pkg::ST_SRCH_ADDR;
      pape_pkg::ST_FETCH:     state_next = pape_pkg::ST_LOAD;
      pape_pkg::ST_LOAD: begin
        state_next = (region == pape_pkg::REG_MID) ? pape_pkg::ST_MUL_A : pape_pkg::ST_MUL_V;
      end
      pape_pkg::ST_MUL_A:     if (mul_rsp.done) state_next = pape_pkg::ST_MUL_V;
      pape_pkg::ST_MUL_V: begin
        if (mul_rsp.done) begin
          state_next = (region == pape_pkg::REG_MID) ? pape_pkg::ST_MUL_AA
                                                     : pape_pkg::ST_FINISH;
        end
      end
      pape_pkg::ST_MUL_AA:    if (mul_rsp.done) state_next = pape_pkg::ST_FINISH;
      pape_pkg::ST_FINISH:    state_next = pape_pkg::ST_DONE;
      pape_pkg::ST_DONE:      if (out_free) state_next = pape_pkg::ST_IDLE;
      default:                state_next = pape_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    q_pop       = (state == pape_pkg::ST_IDLE) && q_valid;
    mul_state   = (state == pape_pkg::ST_MUL_A) || (state == pape_pkg::ST_MUL_V) ||
                  (state == pape_pkg::ST_MUL_AA);
    mul_req.start = mul_state && !mul_issued;
    mul_req.y     = dt_reg;
    case (state)
      pape_pkg::ST_MUL_A: begin
        mul_req.x_neg = a_reg[31];
        mul_req.x_mag = {16'd0, abs32(a_reg)};
      end
      pape_pkg::ST_MUL_AA: begin
        mul_req.x_neg = m1_neg;
        mul_req.x_mag = m1_mag;
      end
      default: begin
        mul_req.x_neg = ks[31];
        mul_req.x_mag = {16'd0, abs32(ks)};
      end
    endcase
    case (state)
      pape_pkg::ST_SRCH_ADDR: raddr = mid[AW-1:0];
      pape_pkg::ST_FETCH:     raddr = (lo == '0) ? '0 : lo_m1[AW-1:0];
      default:                raddr = '0;
    endcase
    wr_knot  = (state == pape_pkg::ST_FINISH) && (cur_op == pape_pkg::OP_APPEND);
    wr_accel = wr_knot && (count != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pape_pkg::ST_IDLE;
      count      <= '0;
      start_pos  <= '0;
      res_valid  <= 1'b0;
      mul_issued <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        start_pos <= start_position;
      end
      if (mul_req.start) begin
        mul_issued <= 1'b1;
      end else if (mul_rsp.done) begin
        mul_issued <= 1'b0;
      end
      if (q_pop && q_item.op == pape_pkg::OP_CLEAR) begin
        count <= '0;
      end else if (wr_knot) begin
        count <= count + 1'b1;
      end
      if (state == pape_pkg::ST_DONE && out_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      pape_pkg::ST_IDLE: begin
        cur_op    <= q_item.op;
        t_reg     <= q_item.time_req;
        vel_reg   <= q_item.velocity;
        pos_stage <= '0;
        spd_stage <= '0;
        acc_stage <= '0;
        lo        <= '0;
        hi        <= count;
        region    <= pape_pkg::REG_MID;
        ks        <= last_speed;
        dt_reg    <= q_item.time_req - last_time;
        div_neg   <= dv[32];
        div_q     <= {dv_mag, 16'd0};
        div_rem   <= '0;
        div_cnt   <= DCW'(pape_pkg::DIV_BITS - 1);
        if (count == '0) begin
          pos_acc <= {{16{start_pos[47]}}, start_pos};
        end else begin
          pos_acc <= {{16{last_pos[47]}}, last_pos};
        end
        if (q_item.op == pape_pkg::OP_APPEND && count == CW'(MAX_KNOTS)) begin
          stat_stage <= pape_pkg::STAT_FULL;
        end else if (q_item.op == pape_pkg::OP_APPEND && count != '0 &&
                     q_item.time_req <= last_time) begin
          stat_stage <= pape_pkg::STAT_ORDER;
        end else if (q_item.op == pape_pkg::OP_QUERY && count < CW'(2)) begin
          stat_stage <= pape_pkg::STAT_FEW;
        end else begin
          stat_stage <= pape_pkg::STAT_OK;
        end
      end
      pape_pkg::ST_DIV: begin
        div_rem <= div_ge ? 32'(div_trial - {1'b0, dt_reg}) : div_trial[31:0];
        div_q   <= div_q_step;
        div_cnt <= div_cnt - 1'b1;
        a_reg   <= div_a;
      end
      pape_pkg::ST_SRCH_CMP: begin
        if (rd_time <= t_reg) begin
          lo <= mid + 1'b1;
        end else begin
          hi <= mid;
        end
      end
      pape_pkg::ST_FETCH: begin
        if (lo == '0) begin
          region <= pape_pkg::REG_BEFORE;
        end else if (lo == count) begin
          region <= pape_pkg::REG_AFTER;
        end else begin
          region <= pape_pkg::REG_MID;
        end
      end
      pape_pkg::ST_LOAD: begin
        ks      <= rd_speed;
        spd_res <= rd_speed;
        a_reg   <= rd_accel;
        acc_res <= (region == pape_pkg::REG_MID) ? rd_accel : 32'd0;
        pos_acc <= {{16{rd_pos[47]}}, rd_pos};
        dt_reg  <= (region == pape_pkg::REG_BEFORE) ? (rd_time - t_reg) : (t_reg - rd_time);
      end
      pape_pkg::ST_MUL_A: begin
        if (mul_rsp.done) begin
          m1_neg  <= mul_rsp.neg;
          m1_mag  <= mul_rsp.mag[47:0];
          spd_res <= spd_sat;
        end
      end
      pape_pkg::ST_MUL_V: begin
        if (mul_rsp.done) begin
          pos_acc <= (region == pape_pkg::REG_BEFORE) ? (pos_acc - mul_s) : (pos_acc + mul_s);
        end
      end
      pape_pkg::ST_MUL_AA: begin
        if (mul_rsp.done) begin
          pos_acc <= pos_acc + mul_half;
        end
      end
      pape_pkg::ST_FINISH: begin
        if (cur_op == pape_pkg::OP_APPEND) begin
          last_time  <= t_reg;
          last_speed <= vel_reg;
          last_pos   <= pos_final;
        end else begin
          pos_stage <= pos_final;
          spd_stage <= spd_res;
          acc_stage <= acc_res;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register, loaded when the finished result can move out.
  always_ff @(posedge clk) begin
    if (state == pape_pkg::ST_DONE && out_free) begin
      position <= pos_stage;
      speed    <= spd_stage;
      accel    <= acc_stage;
      status   <= stat_stage;
    end
  end

  pape_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_time_ram (
    .clk(clk), .we(wr_knot), .waddr(count[AW-1:0]), .wdata(t_reg),
    .raddr(raddr), .rdata(rd_time)
  );

  pape_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_speed_ram (
    .clk(clk), .we(wr_knot), .waddr(count[AW-1:0]), .wdata(vel_reg),
    .raddr(raddr), .rdata(rd_speed)
  );

  pape_ram #(.WIDTH(48), .DEPTH(MAX_KNOTS)) u_pos_ram (
    .clk(clk), .we(wr_knot), .waddr(count[AW-1:0]), .wdata(pos_final),
    .raddr(raddr), .rdata(rd_pos)
  );

  pape_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_accel_ram (
    .clk(clk), .we(wr_accel), .waddr(count_m1[AW-1:0]), .wdata(a_reg),
    .raddr(raddr), .rdata(rd_accel)
  );

  `PAPE_ASSERT_IMP(a_knot_fits, clk, rst, wr_knot, count < CW'(MAX_KNOTS), "knot written to a full table")
  `PAPE_ASSERT_IMP(a_mul_idle, clk, rst, mul_req.start, !mul_rsp.busy, "multiply started while busy")
  `PAPE_ASSERT_NXT(a_pop_leaves, clk, rst, q_pop, state != pape_pkg::ST_IDLE, "request popped but back end idle")
  `PAPE_ASSERT_IMP(a_res_src, clk, rst, $rose(res_valid), $past(state == pape_pkg::ST_DONE), "result without completion")

endmodule

// ----- sv/piecewise_accel_profile_eval_unit.sv -----
// Top level of the piecewise constant-acceleration motion profile evaluation unit.
//
// This unit holds a table of up to MAX_KNOTS velocity knots (time, velocity) and answers
// queries for position, speed and acceleration at a given time. A request with mode 0
// appends a knot, mode 1 queries, mode 2 clears the table; every request yields exactly
// one result. Times, speeds and accelerations are Q16.16, positions Q32.16, and all
// arithmetic saturates. The start_position register gives the first knot's position; the
// user must see that it is written through the cfg channel only while the unit is idle;
// the block itself does not enforce this. A front end decodes requests into a two-entry
// queue, so requests are taken while the back end works or a result waits; the back end
// handles one request at a time. A query inside the table picks up the request, runs the
// upper-bound search over N knots (one table read and one compare per step, plus the
// final exit check), fetches and loads the knot, runs three sequential multiplies (each
// a start step, three 16-bit partial products on one shared multiplier and a done step)
// and then finishes and hands over the result. A query before the first knot or past the
// last needs only one multiply. An append of a later knot runs the 49-step bit-serial
// divider that forms the segment acceleration, followed by the same three multiplies.
// Clears and rejected knots go straight to the result, and the first knot only passes
// the finish step. A stalled result holds the back end in its done state until the result
// can move out. The knot table needs no clearing pass after reset.
module piecewise_accel_profile_eval_unit #(
  parameter int MAX_KNOTS = pape_pkg::MAX_KNOTS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         mode,
  input  logic [31:0]        time_req,
  input  logic signed [31:0] velocity,
  output logic               res_valid,
  input  logic               res_stall,
  output logic signed [47:0] position,
  output logic signed [31:0] speed,
  output logic signed [31:0] accel,
  output logic [1:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [47:0] start_position
);

  // Queue between the front end and the back end.
  logic               q_valid;
  pape_pkg::item_t    q_item;
  logic               q_pop;

  // Shared multiplier request and response.
  pape_pkg::mul_req_t mul_req;
  pape_pkg::mul_rsp_t mul_rsp;

  pape_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .mode      (mode),
    .time_req  (time_req),
    .velocity  (velocity),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  pape_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // The back end owns the knot table, the search and the result register.
  pape_back #(.MAX_KNOTS(MAX_KNOTS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .start_position (start_position),
    .mul_req        (mul_req),
    .mul_rsp        (mul_rsp),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .position       (position),
    .speed          (speed),
    .accel          (accel),
    .status         (status)
  );

endmodule

// ----- verif/piecewise_accel_profile_eval_unit_tb.sv -----
// Self-checking testbench for the piecewise constant-acceleration motion profile unit.
module piecewise_accel_profile_eval_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KNOTS = pape_pkg::MAX_KNOTS_DEFAULT;
  localparam longint CYCLE_LIMIT = 3000000;
  // A later knot append is the slowest request.
  localparam int DRAIN_CYCLES = 120;
  localparam longint POS_HI = 64'sd140737488355327;
  localparam longint POS_LO = -64'sd140737488355328;
  localparam longint SPD_HI = 64'sd2147483647;
  localparam longint SPD_LO = -64'sd2147483648;

  // One result of the unit, as it appears on the result ports.
  typedef struct {
    logic signed [47:0] position;
    logic signed [31:0] speed;
    logic signed [31:0] accel;
    pape_pkg::status_t  status;
  } profile_t;

  // One row of the directed stimulus. Rows with known_result set carry the
  // result typed in by hand; all such rows have zero position, speed and accel.
  typedef struct {
    pape_pkg::op_t     op;
    logic [31:0]       t;
    logic [31:0]       v;
    bit                known_result;
    pape_pkg::status_t status;
  } row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [1:0]         mode = pape_pkg::MODE_CLEAR;
  logic [31:0]        time_req = '0;
  logic signed [31:0] velocity = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  logic signed [47:0] position;
  logic signed [31:0] speed;
  logic signed [31:0] accel;
  logic [1:0]         status;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic signed [47:0] start_position = '0;

  piecewise_accel_profile_eval_unit uut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .mode           (mode),
    .time_req       (time_req),
    .velocity       (velocity),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .position       (position),
    .speed          (speed),
    .accel          (accel),
    .status         (status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .start_position (start_position)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the knot table and the start register, kept by the profile model below.
  logic [31:0] tbl_time [KNOTS];
  longint      tbl_speed [KNOTS];
  longint      tbl_pos [KNOTS];
  longint      tbl_accel [KNOTS];
  int          tbl_count = 0;
  longint      start_reg = 0;

  profile_t pending_results[$];
  int       error_count = 0;
  longint   cycle_count = 0;
  bit       quiet = 1'b0;      // When set, neither side inserts idle cycles.
  bit       hold_req = 1'b0;   // Asks the result side for one long stall.
  bit       hold_taken = 1'b0; // Set by the result side once the long stall has begun.
  int       stall_left = 0;

  function automatic longint clamp64(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  // Fixed-point product of a value with a Q16.16 time: the magnitude is
  // truncated after the shift and clamped to 2^62, the sign is reapplied.
  function automatic longint scale_by_time(longint x, logic [31:0] y);
    bit neg;
    longint unsigned m, mh, ml, r, lim;
    lim = 64'd1 << 62;
    neg = x < 0;
    m = neg ? -x : x;
    mh = m >> 16;
    ml = m & 64'hFFFF;
    if (y != 0 && mh > lim / y) r = lim;
    else begin
      r = mh * y + ((ml * y) >> 16);
      if (r > lim) r = lim;
    end
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // Position reached dt after knot k, following the segment that starts at k.
  // The halving of the quadratic term truncates toward zero.
  function automatic longint segment_reach(int k, logic [31:0] dt);
    longint s;
    s = tbl_pos[k] + scale_by_time(tbl_speed[k], dt)
      + scale_by_time(scale_by_time(tbl_accel[k], dt), dt) / 2;
    return clamp64(s, POS_LO, POS_HI);
  endfunction

  // Applies one accepted request to the shadow table and returns its result.
  function automatic profile_t evaluate_profile(pape_pkg::op_t op, logic [31:0] t,
                                                logic [31:0] v);
    profile_t r;
    longint   pos, spd, acc, dv, dt;
    int       k, p;
    pos = 0;
    spd = 0;
    acc = 0;
    r.status = pape_pkg::STAT_OK;
    case (op)
      pape_pkg::OP_APPEND: begin
        if (tbl_count >= KNOTS) r.status = pape_pkg::STAT_FULL;
        else if (tbl_count > 0 && t <= tbl_time[tbl_count-1]) r.status = pape_pkg::STAT_ORDER;
        else if (tbl_count == 0) begin
          tbl_time[0] = t;
          tbl_speed[0] = longint'(signed'(v));
          tbl_pos[0] = start_reg;
          tbl_count = 1;
        end else begin
          p = tbl_count - 1;
          dt = longint'(t - tbl_time[p]);
          dv = longint'(signed'(v)) - tbl_speed[p];
          tbl_accel[p] = clamp64((dv * 65536) / dt, SPD_LO, SPD_HI);
          tbl_pos[tbl_count] = segment_reach(p, t - tbl_time[p]);
          tbl_time[tbl_count] = t;
          tbl_speed[tbl_count] = longint'(signed'(v));
          tbl_count++;
        end
      end
      pape_pkg::OP_QUERY: begin
        if (tbl_count < 2) r.status = pape_pkg::STAT_FEW;
        else begin
          // Upper-bound search: first knot strictly later than t.
          k = 0;
          while (k < tbl_count && tbl_time[k] <= t) k++;
          if (k == 0) begin
            spd = tbl_speed[0];
            pos = clamp64(tbl_pos[0] - scale_by_time(spd, tbl_time[0] - t), POS_LO, POS_HI);
          end else if (k == tbl_count) begin
            p = tbl_count - 1;
            spd = tbl_speed[p];
            pos = clamp64(tbl_pos[p] + scale_by_time(spd, t - tbl_time[p]), POS_LO, POS_HI);
          end else begin
            p = k - 1;
            acc = tbl_accel[p];
            spd = clamp64(tbl_speed[p] + scale_by_time(acc, t - tbl_time[p]), SPD_LO, SPD_HI);
            pos = segment_reach(p, t - tbl_time[p]);
          end
        end
      end
      pape_pkg::OP_CLEAR: tbl_count = 0;
      default: ;
    endcase
    r.position = pos[47:0];
    r.speed = spd[31:0];
    r.accel = acc[31:0];
    return r;
  endfunction

  // Offers one request and waits until the unit takes it. Valid stays high
  // afterwards, so back-to-back requests need no extra step in between.
  task automatic issue_request(pape_pkg::op_t op, logic [31:0] t, logic [31:0] v,
                               bit known_result = 1'b0,
                               pape_pkg::status_t st = pape_pkg::STAT_OK);
    profile_t r;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_valid <= 1'b1;
    mode <= op;
    time_req <= t;
    velocity <= v;
    do @(posedge clk); while (req_stall);
    r = evaluate_profile(op, t, v);
    if (known_result) begin
      r.position = '0;
      r.speed = '0;
      r.accel = '0;
      r.status = st;
    end
    pending_results.push_back(r);
  endtask

  // Writes start_position once the unit has drained every outstanding request.
  task automatic write_start(logic [47:0] value);
    req_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    start_position <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    start_reg = longint'(signed'(value));
  endtask

  // Velocity: full 32-bit range half of the time, otherwise within 5.0 m/s either way.
  function automatic logic [31:0] pick_speed();
    if ($urandom_range(0, 1)) return $urandom;
    return 32'($signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000);
  endfunction

  // Loads a fresh table with n knots at increasing times, sometimes with a
  // misordered knot thrown in, then queries it. Returns the request count.
  task automatic run_profile_sequence(int n, output int sent);
    longint  t0, step_max, tc;
    logic [31:0] q;
    int      nq;
    sent = 0;
    issue_request(pape_pkg::OP_CLEAR, $urandom, $urandom);
    sent++;
    t0 = $urandom_range(0, 1) ? longint'($urandom_range(0, 32'h0010_0000)) : longint'($urandom);
    step_max = (64'hFFFF_FFFF - t0) / (n + 1);
    if (step_max < 1) step_max = 1;
    tc = t0;
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 15) == 0) begin
        // Misordered knot: at or before the last stored time.
        issue_request(pape_pkg::OP_APPEND,
                      tbl_count > 0 ? tbl_time[tbl_count-1] - $urandom_range(0, 3) : 32'd0,
                      pick_speed());
        sent++;
      end
      if (tc > 64'hFFFF_FFFF) break;
      issue_request(pape_pkg::OP_APPEND, tc[31:0], pick_speed());
      sent++;
      tc = tc + 1 + longint'($urandom_range(0, 32'(step_max - 1)));
    end
    nq = $urandom_range(2, 8);
    for (int i = 0; i < nq; i++) begin
      case ($urandom_range(0, 3))
        0: q = tbl_count > 0 ? tbl_time[$urandom_range(0, tbl_count - 1)] : $urandom;
        1: q = $urandom;
        default: q = tbl_count > 0 ? tbl_time[0] + $urandom_range(0, 32'(tc - t0)) : $urandom;
      endcase
      issue_request(pape_pkg::OP_QUERY, q, $urandom);
      sent++;
    end
  endtask

  // Result side: random short stall bursts, plus one long hold-off
  // on request so that the request queue fills and the input stalls.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_stall <= 1'b1;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      stall_left <= 299;
      res_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // Checks every accepted result against the oldest expectation.
  always @(posedge clk) begin
    profile_t e;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: position %0d status %0d", position, status);
        error_count++;
      end else begin
        e = pending_results.pop_front();
        if (position !== e.position) begin
          $error("position: expected %0d, got %0d", e.position, position);
          error_count++;
        end
        if (speed !== e.speed) begin
          $error("speed: expected %0d, got %0d", e.speed, speed);
          error_count++;
        end
        if (accel !== e.accel) begin
          $error("accel: expected %0d, got %0d", e.accel, accel);
          error_count++;
        end
        if (status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("piecewise_accel_profile_eval_unit_tb: done, errors");
      $finish;
    end
  end

  // Directed rows: empty-table queries, misordered knots, queries before, at,
  // inside and past the knots, extreme times and speeds, the unused mode and clear.
  row_t directed[] = '{
    '{pape_pkg::OP_QUERY,  32'h0001_0000, 32'h0,         1'b1, pape_pkg::STAT_FEW},
    '{pape_pkg::OP_APPEND, 32'h0001_0000, 32'h0,         1'b1, pape_pkg::STAT_OK},
    '{pape_pkg::OP_QUERY,  32'h0001_0000, 32'h0,         1'b1, pape_pkg::STAT_FEW},
    '{pape_pkg::OP_APPEND, 32'h0001_0000, 32'h1234,      1'b1, pape_pkg::STAT_ORDER},
    '{pape_pkg::OP_APPEND, 32'h0000_8000, 32'h1234,      1'b1, pape_pkg::STAT_ORDER},
    '{pape_pkg::OP_APPEND, 32'h0003_0000, 32'h0002_0000, 1'b1, pape_pkg::STAT_OK},
    '{pape_pkg::OP_QUERY,  32'h0000_0000, 32'h0,         1'b0, pape_pkg::STAT_OK},
    '{pape_pkg::OP_QUERY,  32'h0001_0000, 32'h0,         1'b0, pape_pkg::STAT_OK},
    '{pape_pkg::OP_QUERY,  32'h0002_0000, 32'h0,         1'b0, pape_pkg::STAT_OK},
    '{pape_pkg::OP_QUERY,  32'h0003_0000, 32'h0,         1'b0, pape_pkg::STAT_OK},
    '{pape_pkg::OP_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, pape_pkg::STAT_OK},
    '{pape_pkg::OP_APPEND, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, pape_pkg::STAT_OK},
    '{pape_pkg::OP_QUERY,  32'hFFFF_FFF0, 32'h0,         1'b0, pape_pkg::STAT_OK},
    '{pape_pkg::OP_QUERY,  32'hFFFF_FFFF, 32'h0,         1'b0, pape_pkg::STAT_OK},
    '{pape_pkg::OP_APPEND, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, pape_pkg::STAT_ORDER},
    '{pape_pkg::OP_NONE,   32'hA5A5_5A5A, 32'h5A5A_A5A5, 1'b1, pape_pkg::STAT_OK},
    '{pape_pkg::OP_CLEAR,  32'h0,         32'h0,         1'b1, pape_pkg::STAT_OK},
    '{pape_pkg::OP_QUERY,  32'h0,         32'h0,         1'b1, pape_pkg::STAT_FEW},
    '{pape_pkg::OP_APPEND, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1, pape_pkg::STAT_OK},
    '{pape_pkg::OP_APPEND, 32'h0000_0001, 32'h8000_0000, 1'b1, pape_pkg::STAT_OK},
    '{pape_pkg::OP_QUERY,  32'h0000_0000, 32'h0,         1'b0, pape_pkg::STAT_OK},
    '{pape_pkg::OP_QUERY,  32'h0000_0001, 32'h0,         1'b0, pape_pkg::STAT_OK},
    '{pape_pkg::OP_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, pape_pkg::STAT_OK},
    '{pape_pkg::OP_QUERY,  32'h4000_0000, 32'h0,         1'b0, pape_pkg::STAT_OK}
  };

  logic [47:0] start_values[5];

  initial begin
    int phase_items, sent;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      issue_request(directed[i].op, directed[i].t, directed[i].v,
                    directed[i].known_result, directed[i].status);

    // Each phase sets a new start position, extremes first, then random ones.
    start_values[0] = 48'h7FFF_FFFF_FFFF;
    start_values[1] = 48'h8000_0000_0000;
    start_values[2] = 48'h0;
    start_values[3] = 48'({$urandom, $urandom});
    start_values[4] = 48'({$urandom, $urandom});

    for (int ph = 0; ph < 5; ph++) begin
      write_start(start_values[ph]);
      // The final phase runs with neither side idling.
      quiet = (ph == 4);
      if (ph == 2) hold_req = 1'b1;
      phase_items = 0;
      while (phase_items < 100) begin
        if ($urandom_range(0, 9) < 7) begin
          // Mostly short tables; now and then one near the capacity, which may fill up and overflow.
          run_profile_sequence($urandom_range(0, 9) == 0 ? $urandom_range(KNOTS - 2, KNOTS + 2)
                                                        : $urandom_range(1, 10), sent);
          phase_items += sent;
        end else begin
          issue_request(pape_pkg::op_t'($urandom_range(0, 3)), $urandom, $urandom);
          phase_items++;
        end
      end
    end
    req_valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("piecewise_accel_profile_eval_unit_tb: done, clean");
    else
      $display("piecewise_accel_profile_eval_unit_tb: done, errors");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/pape_pkg.sv
sv/pape_ram.sv
sv/pape_mul.sv
sv/pape_front.sv
sv/pape_back.sv
sv/piecewise_accel_profile_eval_unit.sv
verif/piecewise_accel_profile_eval_unit_tb.sv
